// File: src/sfdo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdo_pkg
// Shared widths, operation and status codes and the configuration bundle of
// the sample FIFO.
// ----------------------------------------------------------------------------
package sfdo_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // operations
  localparam func_t FUNC_PUSH  = 2'd0;
  localparam func_t FUNC_DRAIN = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  // result status codes
  localparam status_t ST_ACCEPTED = 3'd0;
  localparam status_t ST_DROPPED  = 3'd1;
  localparam status_t ST_BAD_ID   = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_DRAINED  = 3'd4;
  localparam status_t ST_NOTHING  = 3'd5;
  localparam status_t ST_CLEARED  = 3'd6;

  // configuration register indexes
  localparam cfg_idx_t CFG_CAPACITY = 2'd0;
  localparam cfg_idx_t CFG_FLUSH    = 2'd1;
  localparam cfg_idx_t CFG_DROP     = 2'd2;

  // normalized configuration
  typedef struct packed {
    level_t cap_eff;
    level_t flush_eff;
    logic   drop_en;
  } cfg_t;

endpackage

// File: src/sfdo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdo_req_if / sfdo_rsp_if
// Valid/ready channels carrying requests into and results out of the FIFO.
// ----------------------------------------------------------------------------
interface sfdo_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [sfdo_pkg::FUNC_W-1:0]            func;
  logic [sfdo_pkg::SAMPLE_W-1:0]          sample_data;
  logic                                   identity_ok;
  logic [sfdo_pkg::LEVEL_W-1:0]           drain_limit;

  modport source (output valid, func, sample_data, identity_ok, drain_limit,
                  input ready);
  modport sink   (input valid, func, sample_data, identity_ok, drain_limit,
                  output ready);
endinterface

interface sfdo_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [sfdo_pkg::STATUS_W-1:0]          status;
  logic [sfdo_pkg::SAMPLE_W-1:0]          item_data;
  logic                                   last_item;
  logic [sfdo_pkg::LEVEL_W-1:0]           occupancy;
  logic                                   is_full;
  logic                                   flush_hint;
  logic [sfdo_pkg::TOTAL_W-1:0]           accepted_total;
  logic [sfdo_pkg::TOTAL_W-1:0]           rejected_total;
  logic [sfdo_pkg::TOTAL_W-1:0]           dropped_total;
  logic [sfdo_pkg::TOTAL_W-1:0]           drained_total;

  modport source (output valid, status, item_data, last_item, occupancy, is_full,
                  flush_hint, accepted_total, rejected_total,
                  dropped_total, drained_total,
                  input ready);
  modport sink   (input valid, status, item_data, last_item, occupancy, is_full,
                  flush_hint, accepted_total, rejected_total,
                  dropped_total, drained_total,
                  output ready);
endinterface

// File: src/sample_fifo_drop_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_fifo_drop_oldest
// Bounded sample FIFO with push, drain and clear requests and drop-oldest mode.
// ----------------------------------------------------------------------------
// Push, clear and no-op requests each produce one result, so they stream at
// one request per cycle while results are taken. A drain first issues a read
// of the sample memory, then yields one sample per cycle while results are
// taken, limited by the single read port with its registered read data. A
// new request is taken only after the last result of a drain has been loaded
// into the output register, and only when that register is empty or its
// result leaves in the same cycle. Samples live in one DEPTH x DATA_WIDTH
// memory; pointers, fill count and totals are registers.
module sample_fifo_drop_oldest #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  sfdo_pkg::cfg_idx_t   cfg_idx_i,
  input  sfdo_pkg::level_t     cfg_wdata_i,
  sfdo_req_if.sink             req_i,
  sfdo_rsp_if.source           rsp_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > sfdo_pkg::LEVEL_W) ? CNT_W : sfdo_pkg::LEVEL_W;
  localparam int unsigned CPY_W = (DATA_WIDTH < sfdo_pkg::SAMPLE_W) ? DATA_WIDTH
                                                                    : sfdo_pkg::SAMPLE_W;

  typedef enum logic {S_IDLE, S_DRAIN} state_e;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  sfdo_pkg::cfg_t cfg;

  sfdo_cfg #(.DEPTH(DEPTH)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .wdata_i(cfg_wdata_i),
    .cfg_o  (cfg)
  );

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  sfdo_pkg::level_t    rem_q, rem_d;
  sfdo_pkg::total_t    acc_q, acc_d, rej_q, rej_d, drop_q, drop_d, drn_q, drn_d;

  logic                   out_valid_q, out_valid_d;
  sfdo_pkg::status_t      status_q, status_d;
  logic [sfdo_pkg::SAMPLE_W-1:0] item_q, item_d;
  logic                   last_q, last_d;
  sfdo_pkg::level_t       occ_q, occ_d;
  logic                   full_q, full_d;
  logic                   flush_q, flush_d;

  logic                   ram_we, ram_re;
  logic [PTR_W-1:0]       ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_wdata, ram_rdata;

  logic slot_free, req_acc, load;
  logic [CMP_W-1:0] fill_ext, fill_ext_d, lim_ext, drain_cnt;

  sfdo_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign req_acc     = req_i.valid && req_i.ready;

  assign ram_wdata = DATA_WIDTH'(req_i.sample_data[CPY_W-1:0]);
  assign fill_ext  = CMP_W'(fill_q);
  assign lim_ext   = CMP_W'(req_i.drain_limit);
  assign drain_cnt = (lim_ext < fill_ext) ? lim_ext : fill_ext;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    rej_d     = rej_q;
    drop_d    = drop_q;
    drn_d     = drn_q;
    load      = 1'b0;
    status_d  = sfdo_pkg::ST_NOTHING;
    item_d    = '0;
    last_d    = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          load = 1'b1;
          case (req_i.func)
            sfdo_pkg::FUNC_PUSH: begin
              if (!req_i.identity_ok) begin
                rej_d    = rej_q + sfdo_pkg::total_t'(1);
                status_d = sfdo_pkg::ST_BAD_ID;
              end else if (fill_ext >= CMP_W'(cfg.cap_eff) && !cfg.drop_en) begin
                rej_d    = rej_q + sfdo_pkg::total_t'(1);
                status_d = sfdo_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                tail_d = next_ptr(tail_q);
                acc_d  = acc_q + sfdo_pkg::total_t'(1);
                if (fill_ext >= CMP_W'(cfg.cap_eff)) begin
                  // evict oldest, occupancy unchanged
                  head_d   = next_ptr(head_q);
                  drop_d   = drop_q + sfdo_pkg::total_t'(1);
                  status_d = sfdo_pkg::ST_DROPPED;
                end else begin
                  fill_d   = fill_q + CNT_W'(1);
                  status_d = sfdo_pkg::ST_ACCEPTED;
                end
              end
            end
            sfdo_pkg::FUNC_DRAIN: begin
              if (req_i.drain_limit != '0 && fill_q != '0) begin
                // first read goes out now, results follow from the drain state
                load    = 1'b0;
                rem_d   = sfdo_pkg::level_t'(drain_cnt);
                ram_re  = 1'b1;
                state_d = S_DRAIN;
              end
            end
            sfdo_pkg::FUNC_CLEAR: begin
              head_d   = '0;
              tail_d   = '0;
              fill_d   = '0;
              status_d = sfdo_pkg::ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          load     = 1'b1;
          status_d = sfdo_pkg::ST_DRAINED;
          item_d   = sfdo_pkg::SAMPLE_W'(ram_rdata[CPY_W-1:0]);
          last_d   = (rem_q == sfdo_pkg::level_t'(1));
          head_d   = next_ptr(head_q);
          fill_d   = fill_q - CNT_W'(1);
          drn_d    = drn_q + sfdo_pkg::total_t'(1);
          rem_d    = rem_q - sfdo_pkg::level_t'(1);
          if (rem_q == sfdo_pkg::level_t'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = next_ptr(head_q);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign fill_ext_d  = CMP_W'(fill_d);
  assign occ_d       = fill_ext_d[sfdo_pkg::LEVEL_W-1:0];
  assign full_d      = fill_ext_d >= CMP_W'(cfg.cap_eff);
  assign flush_d     = fill_ext_d >= CMP_W'(cfg.flush_eff);
  assign out_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      rej_q       <= '0;
      drop_q      <= '0;
      drn_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= sfdo_pkg::ST_NOTHING;
      item_q      <= '0;
      last_q      <= 1'b0;
      occ_q       <= '0;
      full_q      <= 1'b0;
      flush_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      rej_q       <= rej_d;
      drop_q      <= drop_d;
      drn_q       <= drn_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        status_q <= status_d;
        item_q   <= item_d;
        last_q   <= last_d;
        occ_q    <= occ_d;
        full_q   <= full_d;
        flush_q  <= flush_d;
      end
    end
  end

  // totals are the live counters, not held in the output register; they only move on load
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.item_data      = item_q;
  assign rsp_o.last_item      = last_q;
  assign rsp_o.occupancy      = occ_q;
  assign rsp_o.is_full        = full_q;
  assign rsp_o.flush_hint     = flush_q;
  assign rsp_o.accepted_total = acc_q;
  assign rsp_o.rejected_total = rej_q;
  assign rsp_o.dropped_total  = drop_q;
  assign rsp_o.drained_total  = drn_q;

endmodule

// File: src/sfdo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfdo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sfdo_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdo_cfg
// Configuration registers with capacity and flush level normalization.
// ----------------------------------------------------------------------------
module sfdo_cfg #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  sfdo_pkg::cfg_idx_t      idx_i,
  input  sfdo_pkg::level_t        wdata_i,
  output sfdo_pkg::cfg_t          cfg_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > sfdo_pkg::LEVEL_W) ? CNT_W : sfdo_pkg::LEVEL_W;

  sfdo_pkg::level_t cap_q;
  sfdo_pkg::level_t flush_q;
  logic             drop_q;
  sfdo_pkg::level_t cap_n;
  sfdo_pkg::level_t flush_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= sfdo_pkg::level_t'(64);
      flush_q <= sfdo_pkg::level_t'(64);
      drop_q  <= 1'b0;
    end else if (we_i) begin
      case (idx_i)
        sfdo_pkg::CFG_CAPACITY: cap_q   <= wdata_i;
        sfdo_pkg::CFG_FLUSH:    flush_q <= wdata_i;
        sfdo_pkg::CFG_DROP:     drop_q  <= wdata_i[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, capacity capped at the store depth, flush capped at capacity
  always_comb begin
    cap_n = (cap_q == '0) ? sfdo_pkg::level_t'(1) : cap_q;
    if (CMP_W'(cap_n) > CMP_W'(DEPTH)) begin
      cap_n = sfdo_pkg::level_t'(DEPTH);
    end
    flush_n = (flush_q == '0) ? sfdo_pkg::level_t'(1) : flush_q;
    if (flush_n > cap_n) begin
      flush_n = cap_n;
    end
  end

  assign cfg_o.cap_eff   = cap_n;
  assign cfg_o.flush_eff = flush_n;
  assign cfg_o.drop_en   = drop_q;

endmodule

// File: src/sfdo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdo_checker
// Port-level checks on the sample FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module sfdo_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input sfdo_pkg::status_t       status_i,
  input logic [sfdo_pkg::SAMPLE_W-1:0] item_data_i,
  input logic                    last_item_i,
  input sfdo_pkg::level_t        occupancy_i,
  input sfdo_pkg::total_t        accepted_total_i
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(item_data_i) && $stable(occupancy_i) && $stable(accepted_total_i))
    else $error("result changed while stalled");

  // only drained samples may continue a multi-result request
  a_not_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !last_item_i |-> status_i == sfdo_pkg::ST_DRAINED)
    else $error("non-final result that is not a drained sample");

  // payload only on drained samples
  a_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != sfdo_pkg::ST_DRAINED |-> item_data_i == '0)
    else $error("item data on a result without a sample");

  // no new request while a drain is still emitting
  a_drain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !last_item_i |-> !req_ready_i)
    else $error("request taken in the middle of a drain");

endmodule

bind sample_fifo_drop_oldest sfdo_checker u_sfdo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .item_data_i     (rsp_o.item_data),
  .last_item_i     (rsp_o.last_item),
  .occupancy_i     (rsp_o.occupancy),
  .accepted_total_i(rsp_o.accepted_total)
);
